/* rtl/gbt_pkg.sv */
package gbt_pkg;

  localparam int MAX_NODES = 64;
  localparam int MAX_EDGES = 256;
  localparam int NODE_W    = $clog2(MAX_NODES);
  localparam int NCNT_W    = NODE_W + 1;
  localparam int EDGE_W    = $clog2(MAX_EDGES);
  localparam int ECNT_W    = EDGE_W + 1;

  localparam logic [1:0] OP_ADD  = 2'd0;
  localparam logic [1:0] OP_TRAV = 2'd1;
  localparam logic [1:0] OP_CLR  = 2'd2;

  localparam logic [1:0] ST_VISIT = 2'd0;
  localparam logic [1:0] ST_OK    = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;
  localparam logic [1:0] ST_BAD   = 2'd3;

  // per node list: first and last edge index
  typedef struct packed {
    logic [EDGE_W-1:0] head;
    logic [EDGE_W-1:0] tail;
  } node_ent_t;

  // edge store entry: link to next edge plus target node
  typedef struct packed {
    logic              nil;
    logic [EDGE_W-1:0] nxt;
    logic [NODE_W-1:0] tgt;
  } edge_ent_t;

  // queue or stack entry: node and its next edge to follow
  typedef struct packed {
    logic              nil;
    logic [EDGE_W-1:0] edge_idx;
    logic [NODE_W-1:0] node;
  } work_ent_t;

  // sequencer to result stage
  typedef struct packed {
    logic              req;
    logic              fin;
    logic [NODE_W-1:0] node;
    logic [1:0]        status;
  } emit_req_t;

  // result stage back to sequencer
  typedef struct packed {
    logic can_emit;
    logic fin_done;
  } emit_ack_t;

  typedef enum logic [12:0] {
    S_IDLE   = 13'b0000000000001,
    S_A_WR   = 13'b0000000000010,
    S_A_LINK = 13'b0000000000100,
    S_SWEEP  = 13'b0000000001000,
    S_B_POP  = 13'b0000000010000,
    S_B_NODE = 13'b0000000100000,
    S_B_HEAD = 13'b0000001000000,
    S_B_EDGE = 13'b0000010000000,
    S_D_PUSH = 13'b0000100000000,
    S_D_TOP  = 13'b0001000000000,
    S_D_LOAD = 13'b0010000000000,
    S_D_EDGE = 13'b0100000000000,
    S_FINISH = 13'b1000000000000
  } state_t;

endpackage

/* rtl/gbt_if.sv */
interface gbt_in_if;
  logic                      valid;
  logic                      ready;
  logic [1:0]                op;
  logic [gbt_pkg::NODE_W-1:0] from_node;
  logic [gbt_pkg::NODE_W-1:0] to_node;
  logic [gbt_pkg::NODE_W-1:0] start_node;
  logic                      depth_first;
  logic                      whole_graph;

  modport source(output valid, op, from_node, to_node, start_node, depth_first,
                 whole_graph, input ready);
  modport sink(input valid, op, from_node, to_node, start_node, depth_first,
               whole_graph, output ready);
endinterface

interface gbt_out_if;
  logic                      valid;
  logic                      ready;
  logic [gbt_pkg::NODE_W-1:0] node;
  logic [1:0]                status;
  logic                      last;

  modport source(output valid, node, status, last, input ready);
  modport sink(input valid, node, status, last, output ready);
endinterface

/* rtl/gbt_ram.sv */
module gbt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read; read data holds while re is low
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* rtl/gbt_emit.sv */
module gbt_emit (
  input  logic                clk,
  input  logic                rst_n,
  input  gbt_pkg::emit_req_t  req,
  output gbt_pkg::emit_ack_t  ack,
  gbt_out_if.source           out_if
);

  logic                       pend_v_r, pend_v_nxt;
  logic [gbt_pkg::NODE_W-1:0] pend_node_r, pend_node_nxt;
  logic [1:0]                 pend_st_r, pend_st_nxt;
  logic                       out_v_r, out_v_nxt;
  logic [gbt_pkg::NODE_W-1:0] out_node_r, out_node_nxt;
  logic [1:0]                 out_st_r, out_st_nxt;
  logic                       out_last_r, out_last_nxt;
  logic                       out_free, push_mid, push_last;

  assign out_free = !out_v_r || out_if.ready;
  assign ack.can_emit = !pend_v_r || out_free;
  assign ack.fin_done = !pend_v_r || out_free;
  assign push_mid  = req.req && pend_v_r && out_free;
  assign push_last = req.fin && pend_v_r && out_free;

  // hold one item back so the final one can be marked last
  always_comb begin
    pend_v_nxt    = pend_v_r;
    pend_node_nxt = pend_node_r;
    pend_st_nxt   = pend_st_r;
    out_v_nxt     = out_v_r;
    out_node_nxt  = out_node_r;
    out_st_nxt    = out_st_r;
    out_last_nxt  = out_last_r;
    if (req.req && ack.can_emit) begin
      pend_v_nxt    = 1'b1;
      pend_node_nxt = req.node;
      pend_st_nxt   = req.status;
    end else if (push_last) begin
      pend_v_nxt = 1'b0;
    end
    if (push_mid || push_last) begin
      out_v_nxt    = 1'b1;
      out_node_nxt = pend_node_r;
      out_st_nxt   = pend_st_r;
      out_last_nxt = push_last;
    end else if (out_if.ready) begin
      out_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_v_r <= 1'b0;
      out_v_r  <= 1'b0;
    end else begin
      pend_v_r <= pend_v_nxt;
      out_v_r  <= out_v_nxt;
    end
    pend_node_r <= pend_node_nxt;
    pend_st_r   <= pend_st_nxt;
    out_node_r  <= out_node_nxt;
    out_st_r    <= out_st_nxt;
    out_last_r  <= out_last_nxt;
  end

  assign out_if.valid  = out_v_r;
  assign out_if.node   = out_node_r;
  assign out_if.status = out_st_r;
  assign out_if.last   = out_last_r;

endmodule

/* rtl/graph_bfs_dfs_traversal.sv */
// Channel   Dir  Handshake          Payload
// in_if     in   valid/ready        op, from_node, to_node, start_node, depth_first, whole_graph
// out_if    out  valid/ready        node, status, last
// cfg       in   cfg_we             cfg_wdata (node_count)
//
// One item at a time. A traversal's pace is set by the single read port of the edge store
// and of the work list memory.
// Reset clears list and visit valid bits at once; no clearing pass.
// A stalled result output stalls the walk only when a new result finds both the held
// result and the output register full.
module graph_bfs_dfs_traversal (
  input  logic                       clk,
  input  logic                       rst_n,
  gbt_in_if.sink                     in_if,
  gbt_out_if.source                  out_if,
  input  logic                       cfg_we,
  input  logic [gbt_pkg::NCNT_W-1:0] cfg_wdata
);

  localparam int NW = gbt_pkg::NODE_W;
  localparam int CW = gbt_pkg::NCNT_W;
  localparam int EW = gbt_pkg::EDGE_W;
  localparam int KW = gbt_pkg::ECNT_W;
  localparam int NN = gbt_pkg::MAX_NODES;

  gbt_pkg::state_t          state_r, state_nxt;
  logic [CW-1:0]            nc_r;
  logic [NN-1:0]            nv_r, nv_nxt;
  logic [NN-1:0]            vis_r, vis_nxt;
  logic [KW-1:0]            ecnt_r, ecnt_nxt;
  logic [NW-1:0]            from_r, from_nxt, to_r, to_nxt, u_r, u_nxt;
  logic                     dfs_r, dfs_nxt, whole_r, whole_nxt;
  logic [CW-1:0]            s_r, s_nxt, rd_r, rd_nxt, wr_r, wr_nxt;
  logic [EW-1:0]            e_r, e_nxt, tail_r, tail_nxt;
  logic                     enil_r, enil_nxt;
  logic [CW-1:0]            n_act;

  logic                     nd_we, nd_re, ed_we, ed_re, wk_we, wk_re;
  logic [NW-1:0]            nd_waddr, nd_raddr, wk_waddr, wk_raddr;
  logic [EW-1:0]            ed_waddr, ed_raddr;
  gbt_pkg::node_ent_t       nd_wdata, nd_rdata;
  gbt_pkg::edge_ent_t       ed_wdata, ed_rdata;
  gbt_pkg::work_ent_t       wk_wdata, wk_rdata;
  gbt_pkg::emit_req_t       em;
  gbt_pkg::emit_ack_t       ack;
  logic                     tgt_ok;

  // clamp node count into 1..MAX_NODES
  always_comb begin
    if (nc_r == '0) begin
      n_act = CW'(1);
    end else if (nc_r > CW'(NN)) begin
      n_act = CW'(NN);
    end else begin
      n_act = nc_r;
    end
  end

  // edge target may be followed
  assign tgt_ok = ({1'b0, ed_rdata.tgt} < n_act) && !vis_r[ed_rdata.tgt]
                  && (wr_r < CW'(NN));

  assign in_if.ready = (state_r == gbt_pkg::S_IDLE);

  always_comb begin
    state_nxt = state_r;
    nv_nxt    = nv_r;
    vis_nxt   = vis_r;
    ecnt_nxt  = ecnt_r;
    from_nxt  = from_r;
    to_nxt    = to_r;
    u_nxt     = u_r;
    dfs_nxt   = dfs_r;
    whole_nxt = whole_r;
    s_nxt     = s_r;
    rd_nxt    = rd_r;
    wr_nxt    = wr_r;
    e_nxt     = e_r;
    tail_nxt  = tail_r;
    enil_nxt  = enil_r;
    nd_we = 1'b0; nd_re = 1'b0; nd_waddr = from_r; nd_raddr = in_if.from_node;
    nd_wdata = '0;
    ed_we = 1'b0; ed_re = 1'b0; ed_waddr = e_r; ed_raddr = e_r; ed_wdata = '0;
    wk_we = 1'b0; wk_re = 1'b0; wk_waddr = wr_r[NW-1:0]; wk_raddr = rd_r[NW-1:0];
    wk_wdata = '0;
    em = '0;

    unique case (state_r)
      gbt_pkg::S_IDLE: begin
        if (in_if.valid) begin
          from_nxt  = in_if.from_node;
          to_nxt    = in_if.to_node;
          dfs_nxt   = in_if.depth_first;
          whole_nxt = in_if.whole_graph;
          state_nxt = gbt_pkg::S_FINISH;
          case (in_if.op)
            gbt_pkg::OP_ADD: begin
              if (({1'b0, in_if.from_node} >= n_act) || ({1'b0, in_if.to_node} >= n_act)) begin
                em.req = 1'b1; em.status = gbt_pkg::ST_BAD;
              end else if (ecnt_r == KW'(gbt_pkg::MAX_EDGES)) begin
                em.req = 1'b1; em.status = gbt_pkg::ST_FULL;
              end else begin
                nd_re     = 1'b1;
                e_nxt     = ecnt_r[EW-1:0];
                state_nxt = gbt_pkg::S_A_WR;
              end
            end
            gbt_pkg::OP_TRAV: begin
              vis_nxt = '0;
              s_nxt   = in_if.whole_graph ? '0 : {1'b0, in_if.start_node};
              if (!in_if.whole_graph && ({1'b0, in_if.start_node} >= n_act)) begin
                em.req = 1'b1; em.status = gbt_pkg::ST_BAD;
              end else begin
                state_nxt = gbt_pkg::S_SWEEP;
              end
            end
            gbt_pkg::OP_CLR: begin
              nv_nxt   = '0;
              ecnt_nxt = '0;
              em.req = 1'b1; em.status = gbt_pkg::ST_OK;
            end
            default: ;
          endcase
        end
      end

      // store new edge and update the list ends
      gbt_pkg::S_A_WR: begin
        ed_we    = 1'b1;
        ed_waddr = e_r;
        ed_wdata = '{nil: 1'b1, nxt: '0, tgt: to_r};
        nd_we    = 1'b1;
        nd_waddr = from_r;
        nd_wdata = '{head: nv_r[from_r] ? nd_rdata.head : e_r, tail: e_r};
        nv_nxt[from_r] = 1'b1;
        ecnt_nxt = ecnt_r + KW'(1);
        em.req = 1'b1; em.status = gbt_pkg::ST_OK;
        if (nv_r[from_r]) begin
          ed_re     = 1'b1;
          ed_raddr  = nd_rdata.tail;
          tail_nxt  = nd_rdata.tail;
          state_nxt = gbt_pkg::S_A_LINK;
        end else begin
          state_nxt = gbt_pkg::S_FINISH;
        end
      end

      // link old tail to the new edge
      gbt_pkg::S_A_LINK: begin
        ed_we     = 1'b1;
        ed_waddr  = tail_r;
        ed_wdata  = '{nil: 1'b0, nxt: e_r, tgt: ed_rdata.tgt};
        state_nxt = gbt_pkg::S_FINISH;
      end

      // pick the next root
      gbt_pkg::S_SWEEP: begin
        if (whole_r && (s_r >= n_act)) begin
          state_nxt = gbt_pkg::S_FINISH;
        end else if (whole_r && vis_r[s_r[NW-1:0]]) begin
          s_nxt = s_r + CW'(1);
        end else if (!dfs_r) begin
          vis_nxt[s_r[NW-1:0]] = 1'b1;
          wk_we     = 1'b1;
          wk_waddr  = '0;
          wk_wdata  = '{nil: 1'b1, edge_idx: '0, node: s_r[NW-1:0]};
          rd_nxt    = '0;
          wr_nxt    = CW'(1);
          state_nxt = gbt_pkg::S_B_POP;
        end else if (ack.can_emit) begin
          em.req = 1'b1; em.node = s_r[NW-1:0]; em.status = gbt_pkg::ST_VISIT;
          vis_nxt[s_r[NW-1:0]] = 1'b1;
          nd_re     = 1'b1;
          nd_raddr  = s_r[NW-1:0];
          u_nxt     = s_r[NW-1:0];
          wr_nxt    = '0;
          state_nxt = gbt_pkg::S_D_PUSH;
        end
      end

      // breadth-first: dequeue
      gbt_pkg::S_B_POP: begin
        if (rd_r == wr_r) begin
          s_nxt     = s_r + CW'(1);
          state_nxt = whole_r ? gbt_pkg::S_SWEEP : gbt_pkg::S_FINISH;
        end else begin
          wk_re     = 1'b1;
          wk_raddr  = rd_r[NW-1:0];
          rd_nxt    = rd_r + CW'(1);
          state_nxt = gbt_pkg::S_B_NODE;
        end
      end

      gbt_pkg::S_B_NODE: begin
        if (ack.can_emit) begin
          em.req = 1'b1; em.node = wk_rdata.node; em.status = gbt_pkg::ST_VISIT;
          nd_re     = 1'b1;
          nd_raddr  = wk_rdata.node;
          u_nxt     = wk_rdata.node;
          state_nxt = gbt_pkg::S_B_HEAD;
        end
      end

      gbt_pkg::S_B_HEAD: begin
        if (!nv_r[u_r]) begin
          state_nxt = gbt_pkg::S_B_POP;
        end else begin
          ed_re     = 1'b1;
          ed_raddr  = nd_rdata.head;
          state_nxt = gbt_pkg::S_B_EDGE;
        end
      end

      // breadth-first: scan one edge a cycle, enqueue new targets
      gbt_pkg::S_B_EDGE: begin
        if (tgt_ok) begin
          vis_nxt[ed_rdata.tgt] = 1'b1;
          wk_we    = 1'b1;
          wk_waddr = wr_r[NW-1:0];
          wk_wdata = '{nil: 1'b1, edge_idx: '0, node: ed_rdata.tgt};
          wr_nxt   = wr_r + CW'(1);
        end
        if (ed_rdata.nil) begin
          state_nxt = gbt_pkg::S_B_POP;
        end else begin
          ed_re    = 1'b1;
          ed_raddr = ed_rdata.nxt;
        end
      end

      // depth-first: push node with its first edge
      gbt_pkg::S_D_PUSH: begin
        wk_we     = 1'b1;
        wk_waddr  = wr_r[NW-1:0];
        wk_wdata  = '{nil: !nv_r[u_r], edge_idx: nd_rdata.head, node: u_r};
        enil_nxt  = !nv_r[u_r];
        e_nxt     = nd_rdata.head;
        wr_nxt    = wr_r + CW'(1);
        state_nxt = gbt_pkg::S_D_TOP;
      end

      gbt_pkg::S_D_TOP: begin
        if (enil_r) begin
          wr_nxt = wr_r - CW'(1);
          if (wr_r == CW'(1)) begin
            s_nxt     = s_r + CW'(1);
            state_nxt = whole_r ? gbt_pkg::S_SWEEP : gbt_pkg::S_FINISH;
          end else begin
            wk_re     = 1'b1;
            wk_raddr  = wr_r[NW-1:0] - NW'(2);
            state_nxt = gbt_pkg::S_D_LOAD;
          end
        end else begin
          ed_re     = 1'b1;
          ed_raddr  = e_r;
          state_nxt = gbt_pkg::S_D_EDGE;
        end
      end

      gbt_pkg::S_D_LOAD: begin
        u_nxt     = wk_rdata.node;
        e_nxt     = wk_rdata.edge_idx;
        enil_nxt  = wk_rdata.nil;
        state_nxt = gbt_pkg::S_D_TOP;
      end

      // depth-first: follow one edge, descend into a new target
      gbt_pkg::S_D_EDGE: begin
        if (tgt_ok) begin
          if (ack.can_emit) begin
            em.req = 1'b1; em.node = ed_rdata.tgt; em.status = gbt_pkg::ST_VISIT;
            vis_nxt[ed_rdata.tgt] = 1'b1;
            wk_we     = 1'b1;
            wk_waddr  = wr_r[NW-1:0] - NW'(1);
            wk_wdata  = '{nil: ed_rdata.nil, edge_idx: ed_rdata.nxt, node: u_r};
            nd_re     = 1'b1;
            nd_raddr  = ed_rdata.tgt;
            u_nxt     = ed_rdata.tgt;
            state_nxt = gbt_pkg::S_D_PUSH;
          end
        end else begin
          e_nxt     = ed_rdata.nxt;
          enil_nxt  = ed_rdata.nil;
          state_nxt = gbt_pkg::S_D_TOP;
        end
      end

      // release the held item marked last
      gbt_pkg::S_FINISH: begin
        em.fin = 1'b1;
        if (ack.fin_done) begin
          state_nxt = gbt_pkg::S_IDLE;
        end
      end

      default: state_nxt = gbt_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= gbt_pkg::S_IDLE;
      nc_r    <= CW'(NN);
      nv_r    <= '0;
      vis_r   <= '0;
      ecnt_r  <= '0;
      rd_r    <= '0;
      wr_r    <= '0;
      s_r     <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        nc_r <= cfg_wdata;
      end
      nv_r    <= nv_nxt;
      vis_r   <= vis_nxt;
      ecnt_r  <= ecnt_nxt;
      rd_r    <= rd_nxt;
      wr_r    <= wr_nxt;
      s_r     <= s_nxt;
    end
    from_r  <= from_nxt;
    to_r    <= to_nxt;
    u_r     <= u_nxt;
    dfs_r   <= dfs_nxt;
    whole_r <= whole_nxt;
    e_r     <= e_nxt;
    tail_r  <= tail_nxt;
    enil_r  <= enil_nxt;
  end

  gbt_ram #(.WIDTH($bits(gbt_pkg::node_ent_t)), .DEPTH(gbt_pkg::MAX_NODES)) u_node_ram (
    .clk(clk), .we(nd_we), .waddr(nd_waddr), .wdata(nd_wdata),
    .re(nd_re), .raddr(nd_raddr), .rdata(nd_rdata)
  );

  gbt_ram #(.WIDTH($bits(gbt_pkg::edge_ent_t)), .DEPTH(gbt_pkg::MAX_EDGES)) u_edge_ram (
    .clk(clk), .we(ed_we), .waddr(ed_waddr), .wdata(ed_wdata),
    .re(ed_re), .raddr(ed_raddr), .rdata(ed_rdata)
  );

  gbt_ram #(.WIDTH($bits(gbt_pkg::work_ent_t)), .DEPTH(gbt_pkg::MAX_NODES)) u_work_ram (
    .clk(clk), .we(wk_we), .waddr(wk_waddr), .wdata(wk_wdata),
    .re(wk_re), .raddr(wk_raddr), .rdata(wk_rdata)
  );

  gbt_emit u_emit (
    .clk(clk), .rst_n(rst_n), .req(em), .ack(ack), .out_if(out_if)
  );

endmodule

/* rtl/gbt_checker.sv */
module gbt_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_valid,
  input logic                       in_ready,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic [gbt_pkg::NODE_W-1:0] out_node,
  input logic [1:0]                 out_status,
  input logic                       out_last
);

  // a stalled item stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // one item in flight: busy right after acceptance
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while busy");

  // status results stand alone
  a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != gbt_pkg::ST_VISIT) |-> out_last)
    else $error("status result not last");

  a_status_node: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != gbt_pkg::ST_VISIT) |-> (out_node == '0))
    else $error("status result with nonzero node");

endmodule

bind graph_bfs_dfs_traversal gbt_checker u_gbt_checker (
  .clk(clk), .rst_n(rst_n),
  .in_valid(in_if.valid), .in_ready(in_if.ready),
  .out_valid(out_if.valid), .out_ready(out_if.ready),
  .out_node(out_if.node), .out_status(out_if.status), .out_last(out_if.last)
);

/* test/tb_graph_bfs_dfs_traversal.sv */
module tb_graph_bfs_dfs_traversal;
  import gbt_pkg::*;

  localparam logic [1:0] OP_NONE = 2'd3;  // unused code, block drops it
  localparam int WATCHDOG = 40000;
  localparam int SETTLE = 40;

  typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

  typedef struct {
    row_kind_t  kind;
    logic [1:0] op;
    logic [5:0] from_node;
    logic [5:0] to_node;
    logic [5:0] start_node;
    logic       depth_first;
    logic       whole_graph;
    logic       has_status;
    logic [1:0] first_status;
    logic [6:0] nodes;
  } stim_row_t;

  typedef struct {
    logic [5:0] node;
    logic [1:0] status;
    logic       last;
  } visit_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [NCNT_W-1:0] cfg_wdata;

  gbt_in_if  in_ch ();
  gbt_out_if out_ch ();

  graph_bfs_dfs_traversal dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_if    (in_ch),
    .out_if   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  // graph mirror
  int     list_first [MAX_NODES];
  int     list_last  [MAX_NODES];
  int     edge_dst   [MAX_EDGES];
  int     edge_link  [MAX_EDGES];
  int     edge_total;
  int     node_reg;
  bit     seen [MAX_NODES];
  int     walk_node [MAX_NODES];
  int     walk_edge [MAX_NODES];
  visit_t pending_visits[$];

  int fails;
  int snd_idle_pct;
  int rcv_idle_pct;
  int quiet_cycles;
  int items_sent;

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  task automatic report(string what);
    $display("mismatch at %0t: %s", $time, what);
    fails++;
  endtask

  function automatic int nodes_in_use();
    if (node_reg < 1) return 1;
    if (node_reg > MAX_NODES) return MAX_NODES;
    return node_reg;
  endfunction

  function automatic void push_visit(int node, logic [1:0] status);
    visit_t v;
    v.node = node[5:0];
    v.status = status;
    v.last = 1'b0;
    pending_visits.insert(pending_visits.size(), v);
  endfunction

  function automatic void wipe_graph();
    for (int i = 0; i < MAX_NODES; i++) begin
      list_first[i] = MAX_EDGES;
      list_last[i] = MAX_EDGES;
    end
    edge_total = 0;
  endfunction

  function automatic void walk_breadth(int start, int n);
    int rd;
    int wr;
    int u;
    int e;
    int t;
    rd = 0;
    wr = 0;
    seen[start] = 1;
    walk_node[wr++] = start;
    while (rd < wr) begin
      u = walk_node[rd++];
      push_visit(u, ST_VISIT);
      e = list_first[u];
      while (e < MAX_EDGES) begin
        t = edge_dst[e];
        if (t < n && !seen[t] && wr < MAX_NODES) begin
          seen[t] = 1;
          walk_node[wr++] = t;
        end
        e = edge_link[e];
      end
    end
  endfunction

  function automatic void walk_depth(int start, int n);
    int sp;
    int e;
    int t;
    sp = 0;
    seen[start] = 1;
    push_visit(start, ST_VISIT);
    walk_node[sp] = start;
    walk_edge[sp++] = list_first[start];
    while (sp > 0) begin
      e = walk_edge[sp-1];
      if (e >= MAX_EDGES) begin
        sp--;
        continue;
      end
      walk_edge[sp-1] = edge_link[e];
      t = edge_dst[e];
      if (t < n && !seen[t] && sp < MAX_NODES) begin
        seen[t] = 1;
        push_visit(t, ST_VISIT);
        walk_node[sp] = t;
        walk_edge[sp++] = list_first[t];
      end
    end
  endfunction

  // work out the results of one accepted item
  function automatic void predict_visits(logic [1:0] op, int from_n, int to_n, int start_n,
                                         bit dfs, bit whole);
    int n;
    int q_start;
    int e;
    n = nodes_in_use();
    q_start = pending_visits.size();
    case (op)
      OP_ADD: begin
        if (from_n >= n || to_n >= n) begin
          push_visit(0, ST_BAD);
        end else if (edge_total >= MAX_EDGES) begin
          push_visit(0, ST_FULL);
        end else begin
          e = edge_total++;
          edge_dst[e] = to_n;
          edge_link[e] = MAX_EDGES;
          if (list_last[from_n] < MAX_EDGES) edge_link[list_last[from_n]] = e;
          else list_first[from_n] = e;
          list_last[from_n] = e;
          push_visit(0, ST_OK);
        end
      end
      OP_CLR: begin
        wipe_graph();
        push_visit(0, ST_OK);
      end
      OP_TRAV: begin
        for (int i = 0; i < MAX_NODES; i++) seen[i] = 0;
        if (whole) begin
          for (int s = 0; s < n; s++) begin
            if (seen[s]) continue;
            if (dfs) walk_depth(s, n);
            else walk_breadth(s, n);
          end
        end else if (start_n >= n) begin
          push_visit(0, ST_BAD);
        end else if (dfs) begin
          walk_depth(start_n, n);
        end else begin
          walk_breadth(start_n, n);
        end
      end
      default: ;
    endcase
    if (pending_visits.size() > q_start)
      pending_visits[pending_visits.size()-1].last = 1'b1;
  endfunction

  // hold the item until accepted, then predict; called on a clock edge
  task automatic send_item(logic [1:0] op, logic [5:0] from_n, logic [5:0] to_n,
                           logic [5:0] start_n, logic dfs, logic whole,
                           logic has_status = 1'b0, logic [1:0] first_status = ST_VISIT);
    int gap;
    int q_start;
    if ($urandom_range(99) < snd_idle_pct) begin
      gap = $urandom_range(4, 1);
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.op <= op;
    in_ch.from_node <= from_n;
    in_ch.to_node <= to_n;
    in_ch.start_node <= start_n;
    in_ch.depth_first <= dfs;
    in_ch.whole_graph <= whole;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    q_start = pending_visits.size();
    predict_visits(op, from_n, to_n, start_n, dfs, whole);
    if (has_status && (pending_visits.size() == q_start ||
                       pending_visits[q_start].status != first_status))
      report($sformatf("op %0d: first status not %0d", op, first_status));
    if (op != OP_NONE) items_sent++;
  endtask

  // hold input until every expected result is back
  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_visits.size() != 0) @(posedge clk);
  endtask

  task automatic write_nodes(logic [6:0] value);
    drain();
    repeat (SETTLE) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    node_reg = value;
  endtask

  task automatic send_random_add(bit in_range);
    int n;
    n = nodes_in_use();
    if (in_range)
      send_item(OP_ADD, 6'($urandom_range(n - 1)), 6'($urandom_range(n - 1)),
                6'($urandom_range(63)), 1'($urandom_range(1)), 1'($urandom_range(1)));
    else
      send_item(OP_ADD, 6'($urandom_range(63)), 6'($urandom_range(63)),
                6'($urandom_range(63)), 1'($urandom_range(1)), 1'($urandom_range(1)));
  endtask

  // random graphs built and walked, with some noise items between
  task automatic random_phase(int count);
    int n;
    int adds;
    int stop;
    stop = items_sent + count;
    while (items_sent < stop) begin
      n = nodes_in_use();
      if ($urandom_range(99) < 70) begin
        if ($urandom_range(3) == 0)
          send_item(OP_CLR, 6'($urandom_range(63)), 6'($urandom_range(63)),
                    6'($urandom_range(63)), 1'($urandom_range(1)), 1'($urandom_range(1)));
        adds = $urandom_range(8, 1);
        repeat (adds) send_random_add($urandom_range(9) != 0);
        send_item(OP_TRAV, 6'($urandom_range(63)), 6'($urandom_range(63)),
                  ($urandom_range(7) == 0) ? 6'($urandom_range(63)) : 6'($urandom_range(n - 1)),
                  1'($urandom_range(1)), 1'($urandom_range(1)));
      end else begin
        send_item(2'($urandom_range(3)), 6'($urandom_range(63)), 6'($urandom_range(63)),
                  6'($urandom_range(63)), 1'($urandom_range(1)), 1'($urandom_range(1)));
      end
    end
  endtask

  stim_row_t plan[$];

  function automatic void add_row(row_kind_t kind, logic [1:0] op, int from_n, int to_n,
                                  int start_n, bit dfs, bit whole, bit has_status,
                                  logic [1:0] status, int nodes);
    stim_row_t r;
    r.kind = kind;
    r.op = op;
    r.from_node = 6'(from_n);
    r.to_node = 6'(to_n);
    r.start_node = 6'(start_n);
    r.depth_first = dfs;
    r.whole_graph = whole;
    r.has_status = has_status;
    r.first_status = status;
    r.nodes = 7'(nodes);
    plan.insert(plan.size(), r);
  endfunction

  // compare each result with the oldest expectation
  always @(posedge clk) begin
    visit_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_visits.size() == 0) begin
        report($sformatf("result node %0d status %0d with nothing expected",
                         out_ch.node, out_ch.status));
      end else begin
        want = pending_visits.pop_front();
        if (out_ch.node !== want.node)
          report($sformatf("node %0d, want %0d", out_ch.node, want.node));
        if (out_ch.status !== want.status)
          report($sformatf("status %0d, want %0d", out_ch.status, want.status));
        if (out_ch.last !== want.last)
          report($sformatf("last %0b, want %0b", out_ch.last, want.last));
      end
    end
  end

  // random result stalls
  always @(posedge clk) begin
    out_ch.ready <= ($urandom_range(99) >= rcv_idle_pct);
  end

  // stop a hung run
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || !rst_n)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > WATCHDOG) begin
      $display("tb_graph_bfs_dfs_traversal NOT OK");
      $finish;
    end
  end

  initial begin
    fails = 0;
    items_sent = 0;
    snd_idle_pct = 13;
    rcv_idle_pct = 82;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    in_ch.valid = 1'b0;
    in_ch.op = OP_ADD;
    in_ch.from_node = '0;
    in_ch.to_node = '0;
    in_ch.start_node = '0;
    in_ch.depth_first = 1'b0;
    in_ch.whole_graph = 1'b0;
    node_reg = MAX_NODES;
    wipe_graph();

    // directed rows: empty graph, extremes, cycles, shrunk count, clamps
    add_row(ROW_ITEM, OP_TRAV, 0, 0, 0, 0, 0, 1, ST_VISIT, 0);
    add_row(ROW_ITEM, OP_TRAV, 0, 0, 63, 1, 0, 1, ST_VISIT, 0);
    add_row(ROW_ITEM, OP_ADD, 0, 63, 0, 0, 0, 1, ST_OK, 0);
    add_row(ROW_ITEM, OP_ADD, 63, 0, 0, 0, 0, 1, ST_OK, 0);
    add_row(ROW_ITEM, OP_ADD, 0, 1, 0, 0, 0, 1, ST_OK, 0);
    add_row(ROW_ITEM, OP_ADD, 1, 2, 0, 0, 0, 1, ST_OK, 0);
    add_row(ROW_ITEM, OP_ADD, 2, 0, 0, 0, 0, 1, ST_OK, 0);
    add_row(ROW_ITEM, OP_ADD, 1, 3, 0, 0, 0, 1, ST_OK, 0);
    add_row(ROW_ITEM, OP_ADD, 3, 3, 0, 0, 0, 1, ST_OK, 0);
    add_row(ROW_ITEM, OP_TRAV, 0, 0, 0, 0, 0, 0, ST_VISIT, 0);
    add_row(ROW_ITEM, OP_TRAV, 0, 0, 0, 1, 0, 0, ST_VISIT, 0);
    add_row(ROW_ITEM, OP_TRAV, 0, 0, 0, 1, 1, 0, ST_VISIT, 0);
    add_row(ROW_ITEM, OP_NONE, 63, 63, 63, 1, 1, 0, ST_VISIT, 0);
    add_row(ROW_CFG, OP_ADD, 0, 0, 0, 0, 0, 0, ST_VISIT, 4);
    add_row(ROW_ITEM, OP_ADD, 5, 1, 0, 0, 0, 1, ST_BAD, 0);
    add_row(ROW_ITEM, OP_ADD, 1, 4, 0, 0, 0, 1, ST_BAD, 0);
    add_row(ROW_ITEM, OP_TRAV, 0, 0, 4, 0, 0, 1, ST_BAD, 0);
    add_row(ROW_ITEM, OP_TRAV, 0, 0, 0, 1, 1, 0, ST_VISIT, 0);
    add_row(ROW_ITEM, OP_TRAV, 0, 0, 0, 0, 1, 0, ST_VISIT, 0);
    add_row(ROW_CFG, OP_ADD, 0, 0, 0, 0, 0, 0, ST_VISIT, 0);
    add_row(ROW_ITEM, OP_TRAV, 0, 0, 0, 0, 1, 1, ST_VISIT, 0);
    add_row(ROW_ITEM, OP_ADD, 0, 1, 0, 0, 0, 1, ST_BAD, 0);
    add_row(ROW_CFG, OP_ADD, 0, 0, 0, 0, 0, 0, ST_VISIT, 127);
    add_row(ROW_ITEM, OP_TRAV, 0, 0, 0, 1, 1, 0, ST_VISIT, 0);
    add_row(ROW_ITEM, OP_CLR, 0, 0, 0, 0, 0, 1, ST_OK, 0);
    add_row(ROW_ITEM, OP_TRAV, 0, 0, 63, 0, 0, 1, ST_VISIT, 0);

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_CFG)
        write_nodes(plan[i].nodes);
      else
        send_item(plan[i].op, plan[i].from_node, plan[i].to_node, plan[i].start_node,
                  plan[i].depth_first, plan[i].whole_graph, plan[i].has_status,
                  plan[i].first_status);
    end

    // sender rarely idles, receiver mostly stalls
    write_nodes(7'd8);
    random_phase(20);
    drain();
    write_nodes(7'd1);
    random_phase(8);

    // sender mostly idles, receiver rarely stalls
    snd_idle_pct = 82;
    rcv_idle_pct = 13;
    write_nodes(7'd64);
    random_phase(20);
    write_nodes(7'd20);
    random_phase(15);

    // no idling: build a graph, walk it whole, shrink the count, then more random
    snd_idle_pct = 0;
    rcv_idle_pct = 0;
    write_nodes(7'd64);
    send_item(OP_CLR, 0, 0, 0, 0, 0, 1, ST_OK);
    repeat (8) send_random_add(1);
    send_item(OP_TRAV, 0, 0, 0, 0, 1);
    send_item(OP_TRAV, 0, 0, 0, 1, 1);
    write_nodes(7'd33);
    send_item(OP_TRAV, 0, 0, 32, 1, 0);
    send_item(OP_CLR, 0, 0, 0, 0, 0, 1, ST_OK);
    random_phase(15);

    drain();
    repeat (SETTLE) @(posedge clk);
    if (fails == 0)
      $display("tb_graph_bfs_dfs_traversal OK");
    else
      $display("tb_graph_bfs_dfs_traversal NOT OK");
    $finish;
  end

endmodule
